// File: design/clre_pkg.sv
// Shared types, constants and init schedule tables for the character LCD refresh engine.
`timescale 1ns / 1ps

package clre_pkg;

   localparam int COLUMNS    = 16;
   localparam int FRAME_SIZE = 2 * COLUMNS;
   localparam int ADDR_W     = $clog2(FRAME_SIZE);
   localparam int STEP_W     = 4;
   localparam int WAIT_W     = 7;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FRAME_SIZE - 1);
   localparam logic [ADDR_W-1:0] ROW1_ADDR = ADDR_W'(COLUMNS);
   localparam logic [STEP_W-1:0] INIT_STEPS = STEP_W'(9);

   localparam logic [7:0] SPACE_CHAR   = 8'h20;
   localparam logic [7:0] SET_DDRAM_R0 = 8'h80;
   localparam logic [7:0] SET_DDRAM_R1 = 8'hC0;

   typedef enum logic [1:0] {
      CMD_PUT_CHAR = 2'd0,
      CMD_GOTO     = 2'd1,
      CMD_TICK     = 2'd2
   } command_type;

   typedef enum logic [1:0] {
      PH_TOP_ADDR = 2'd0,
      PH_TOP_DATA = 2'd1,
      PH_BOT_ADDR = 2'd2,
      PH_BOT_DATA = 2'd3
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic       is_byte;
      logic       rs;
      logic [7:0] code;
   } emit_type;

   function automatic logic [WAIT_W-1:0] init_wait(input logic [STEP_W-1:0] step);
      case (step)
         4'd0:    init_wait = 7'd100;
         4'd1:    init_wait = 7'd15;
         4'd2:    init_wait = 7'd5;
         4'd3:    init_wait = 7'd5;
         4'd4:    init_wait = 7'd1;
         4'd5:    init_wait = 7'd2;
         4'd6:    init_wait = 7'd2;
         4'd7:    init_wait = 7'd3;
         4'd8:    init_wait = 7'd2;
         default: init_wait = 7'd0;
      endcase
   endfunction

   function automatic logic [7:0] init_code(input logic [STEP_W-1:0] step);
      case (step)
         4'd0:    init_code = 8'h03;
         4'd1:    init_code = 8'h03;
         4'd2:    init_code = 8'h03;
         4'd3:    init_code = 8'h02;
         4'd4:    init_code = 8'h28;
         4'd5:    init_code = 8'h08;
         4'd6:    init_code = 8'h01;
         4'd7:    init_code = 8'h06;
         4'd8:    init_code = 8'h0C;
         default: init_code = 8'h00;
      endcase
   endfunction

   function automatic logic init_is_byte(input logic [STEP_W-1:0] step);
      init_is_byte = (step >= STEP_W'(4)) && (step < INIT_STEPS);
   endfunction

endpackage

// File: design/clre_tick_seq.sv
// Tick sequencer: power-on init schedule followed by the cyclic refresh byte order.
`timescale 1ns / 1ps

module clre_tick_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         tick_go,
   output logic [clre_pkg::ADDR_W-1:0]  frame_addr,
   input  logic [7:0]                   frame_data,
   output clre_pkg::emit_type           emit
);

   logic [clre_pkg::STEP_W-1:0] step_ff, step_in;
   logic [clre_pkg::WAIT_W-1:0] wait_ff, wait_in;
   logic                        done_ff, done_in;
   clre_pkg::phase_type         phase_ff, phase_in;
   logic [clre_pkg::ADDR_W-1:0] scan_ff, scan_in;

   logic [clre_pkg::WAIT_W-1:0] wait_inc;
   logic [clre_pkg::WAIT_W-1:0] step_wait;
   logic [7:0]                  step_code;
   logic                        step_reached;
   logic [clre_pkg::ADDR_W-1:0] scan_inc;

   assign wait_inc     = wait_ff + clre_pkg::WAIT_W'(1);
   assign step_wait    = clre_pkg::init_wait(step_ff);
   assign step_code    = clre_pkg::init_code(step_ff);
   assign step_reached = (step_ff < clre_pkg::INIT_STEPS) && (wait_inc >= step_wait);
   assign scan_inc     = (scan_ff == clre_pkg::LAST_ADDR) ? '0
                                                         : scan_ff + clre_pkg::ADDR_W'(1);
   assign frame_addr   = scan_ff;

   always_comb begin
      step_in  = step_ff;
      wait_in  = wait_ff;
      done_in  = done_ff;
      phase_in = phase_ff;
      scan_in  = scan_ff;
      if (tick_go) begin
         if (!done_ff) begin
            if (step_ff >= clre_pkg::INIT_STEPS) begin
               done_in = 1'b1;
            end else if (!step_reached) begin
               wait_in = wait_inc;
            end else begin
               wait_in = '0;
               step_in = step_ff + clre_pkg::STEP_W'(1);
               if (step_in >= clre_pkg::INIT_STEPS) begin
                  done_in = 1'b1;
               end
            end
         end else begin
            case (phase_ff)
               clre_pkg::PH_TOP_ADDR: begin
                  scan_in  = '0;
                  phase_in = clre_pkg::PH_TOP_DATA;
               end
               clre_pkg::PH_TOP_DATA: begin
                  scan_in = scan_inc;
                  if (scan_inc == clre_pkg::ROW1_ADDR) begin
                     phase_in = clre_pkg::PH_BOT_ADDR;
                  end
               end
               clre_pkg::PH_BOT_ADDR: begin
                  phase_in = clre_pkg::PH_BOT_DATA;
               end
               clre_pkg::PH_BOT_DATA: begin
                  scan_in = scan_inc;
                  if (scan_inc == '0) begin
                     phase_in = clre_pkg::PH_TOP_ADDR;
                  end
               end
               default: begin
                  phase_in = clre_pkg::PH_TOP_ADDR;
               end
            endcase
         end
      end
   end

   always_comb begin
      emit = '0;
      if (!done_ff) begin
         if (step_reached) begin
            emit.valid   = 1'b1;
            emit.is_byte = clre_pkg::init_is_byte(step_ff);
            emit.code    = emit.is_byte ? step_code : {6'b0, step_code[1:0]};
         end
      end else begin
         emit.valid   = 1'b1;
         emit.is_byte = 1'b1;
         case (phase_ff)
            clre_pkg::PH_TOP_ADDR: emit.code = clre_pkg::SET_DDRAM_R0;
            clre_pkg::PH_BOT_ADDR: emit.code = clre_pkg::SET_DDRAM_R1;
            clre_pkg::PH_TOP_DATA,
            clre_pkg::PH_BOT_DATA: begin
               emit.rs   = 1'b1;
               emit.code = frame_data;
            end
            default: emit.code = clre_pkg::SET_DDRAM_R0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         wait_ff  <= '0;
         done_ff  <= 1'b0;
         phase_ff <= clre_pkg::PH_TOP_ADDR;
         scan_ff  <= '0;
      end else begin
         step_ff  <= step_in;
         wait_ff  <= wait_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
         scan_ff  <= scan_in;
      end
   end

endmodule

// File: design/char_lcd_refresh_engine_unit.sv
// Top level of the character LCD refresh engine: frame store, cursor and nibble output buffer.
`timescale 1ns / 1ps

// The request channel carries one item per transfer: put character at the cursor, move the
// cursor to a column and row, or a one millisecond tick. Put character and move cursor take
// effect at their transfer, produce no response and are accepted in every cycle.
// A tick first advances the power-on init schedule; a tick that only waits produces nothing.
// Once init is complete, every tick sends one refresh byte in the order row 0 address, row 0
// characters, row 1 address, row 1 characters, and then starts over.
// The response channel carries one nibble per transfer with its register select bit; a byte
// goes out as high nibble then low nibble, and last marks the final nibble of the tick.
// Latency: the first nibble of a tick is offered in the cycle after the tick's transfer.
// A tick that sends a byte fills the two-nibble output buffer, and no further tick is taken
// until it drains; the next tick is taken in the same cycle that the final nibble leaves.
// When the receiver stalls, the current nibble holds and further ticks are stalled, while
// put character and move cursor are still taken.
// Reset clears the frame to spaces, the cursor and the init schedule, and empties the output buffer.

module char_lcd_refresh_engine_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_command,
   input  logic [7:0] req_char_code,
   input  logic [3:0] req_column,
   input  logic       req_row,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_register_select,
   output logic [3:0] rsp_nibble,
   output logic       rsp_last
);

   logic [7:0]                  frame_ff [clre_pkg::FRAME_SIZE];
   logic [clre_pkg::ADDR_W-1:0] cursor_ff, cursor_in;
   logic [1:0]                  count_ff, count_in;
   logic [3:0]                  hi_ff, hi_in;
   logic [3:0]                  lo_ff, lo_in;
   logic                        rs_ff, rs_in;

   logic                        is_tick;
   logic                        buf_free;
   logic                        rsp_xfer;
   logic                        req_xfer;
   logic                        tick_go;
   logic                        put_go;
   logic [clre_pkg::ADDR_W-1:0] frame_addr;
   logic [7:0]                  frame_data;
   logic [clre_pkg::ADDR_W:0]   goto_sum;
   clre_pkg::emit_type          emit;

   assign is_tick   = (req_command == clre_pkg::CMD_TICK);
   assign rsp_xfer  = rsp_valid && !rsp_stall;
   assign buf_free  = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_xfer);
   assign req_stall = is_tick && !buf_free;
   assign req_xfer  = req_valid && !req_stall;
   assign tick_go   = req_xfer && is_tick;
   assign put_go    = req_xfer && (req_command == clre_pkg::CMD_PUT_CHAR);
   assign frame_data = frame_ff[frame_addr];

   assign goto_sum = {1'b0, clre_pkg::ADDR_W'(req_column)}
                   + (req_row ? {1'b0, clre_pkg::ROW1_ADDR} : '0);

   clre_tick_seq u_tick_seq (
      .clock      (clock),
      .reset      (reset),
      .tick_go    (tick_go),
      .frame_addr (frame_addr),
      .frame_data (frame_data),
      .emit       (emit)
   );

   always_comb begin
      cursor_in = cursor_ff;
      if (req_xfer) begin
         case (req_command)
            clre_pkg::CMD_PUT_CHAR: begin
               cursor_in = (cursor_ff == clre_pkg::LAST_ADDR) ? '0
                                                              : cursor_ff + clre_pkg::ADDR_W'(1);
            end
            clre_pkg::CMD_GOTO: begin
               if (goto_sum >= (clre_pkg::ADDR_W+1)'(clre_pkg::FRAME_SIZE)) begin
                  cursor_in = clre_pkg::ADDR_W'(goto_sum
                                 - (clre_pkg::ADDR_W+1)'(clre_pkg::FRAME_SIZE));
               end else begin
                  cursor_in = goto_sum[clre_pkg::ADDR_W-1:0];
               end
            end
            default: cursor_in = cursor_ff;
         endcase
      end
   end

   always_comb begin
      count_in = count_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      rs_in    = rs_ff;
      if (tick_go && emit.valid) begin
         count_in = emit.is_byte ? 2'd2 : 2'd1;
         hi_in    = emit.code[7:4];
         lo_in    = emit.code[3:0];
         rs_in    = emit.rs;
      end else if (rsp_xfer) begin
         count_in = count_ff - 2'd1;
      end
   end

   assign rsp_valid           = (count_ff != 2'd0);
   assign rsp_register_select = rs_ff;
   assign rsp_nibble          = (count_ff == 2'd2) ? hi_ff : lo_ff;
   assign rsp_last            = (count_ff == 2'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         count_ff  <= 2'd0;
         for (int i = 0; i < clre_pkg::FRAME_SIZE; i++) begin
            frame_ff[i] <= clre_pkg::SPACE_CHAR;
         end
      end else begin
         cursor_ff <= cursor_in;
         count_ff  <= count_in;
         if (put_go) begin
            frame_ff[cursor_ff] <= req_char_code;
         end
      end
   end

   always_ff @(posedge clock) begin
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      rs_ff <= rs_in;
   end

endmodule

// File: design/clre_checker.sv
// Port-level assertions for the character LCD refresh engine and their bind to the top level.
`timescale 1ns / 1ps

module clre_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [1:0] req_command,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_register_select,
   input logic [3:0] rsp_nibble,
   input logic       rsp_last
);

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Response offered right after reset.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_nibble)
                                    && $stable(rsp_register_select) && $stable(rsp_last)))
      else $error("Stalled response changed.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=> (rsp_valid && rsp_last))
      else $error("High nibble transfer not followed by its low nibble.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last)
         |=> (rsp_register_select == $past(rsp_register_select)))
      else $error("Register select changed within one byte.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last && req_valid && (req_command == clre_pkg::CMD_TICK))
         |-> req_stall)
      else $error("Tick accepted while a byte was still pending.");

endmodule

bind char_lcd_refresh_engine_unit clre_checker u_clre_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .req_command         (req_command),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_register_select (rsp_register_select),
   .rsp_nibble          (rsp_nibble),
   .rsp_last            (rsp_last)
);
